// ===== rtl/segment_intersection_test_unit_defines.svh =====
// assertion macros shared by the segment intersection rtl
// every macro samples on clock and is held off during reset
`ifndef SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_TEST_UNIT_DEFINES_SVH

// condition must never hold
`define SEGIT_ASSERT_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SEGIT_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/segit_pkg.sv =====
// shared constants and types for the segment intersection unit
// no dependencies
package segit_pkg;

   localparam int COORD_BITS_DEF = 16;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int QUEUE_DEPTH    = 4;

   typedef enum logic [2:0] {
      HIT_NONE    = 3'd0,
      HIT_B_START = 3'd1,
      HIT_B_END   = 3'd2,
      HIT_A_START = 3'd3,
      HIT_A_END   = 3'd4,
      HIT_CROSS   = 3'd5
   } hit_kind_type;

endpackage

// ===== rtl/segit_if.sv =====
// valid/ready channel interfaces for segment pairs and hit results
// depends on segit_pkg
interface seg_req_if #(parameter int COORD_BITS = segit_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (output valid, a_start_x, a_start_y, a_end_x, a_end_y,
                   b_start_x, b_start_y, b_end_x, b_end_y, input ready);
   modport sink (input valid, a_start_x, a_start_y, a_end_x, a_end_y,
                 b_start_x, b_start_y, b_end_x, b_end_y, output ready);
endinterface

interface seg_rsp_if;
   logic                     valid;
   logic                     ready;
   segit_pkg::hit_kind_type  hit_kind;
   logic signed [31:0]       point_x;
   logic signed [31:0]       point_y;

   modport source (output valid, hit_kind, point_x, point_y, input ready);
   modport sink (input valid, hit_kind, point_x, point_y, output ready);
endinterface

// ===== rtl/segment_intersection_test_unit.sv =====
// channel   dir  handshake      payload
// req_ch    in   valid/ready    a/b start and end points, COORD_BITS each
// rsp_ch    out  valid/ready    hit_kind, point_x, point_y (FRAC_BITS fraction)
//
// one item per cycle sustained while rsp_ch is ready
// each divide stage takes one multiplier bit; data passes two front stages,
// the queue, COORD_BITS + 1 + FRAC_BITS divide stages and the output register
// synchronous reset clears all valid flags and queue pointers, no clearing pass
// a stalled rsp_ch freezes the divider; the queue lets the front keep taking items
// top level of the segment intersection unit; depends on segit_pkg, segit_if,
// segit_front, segit_queue and segit_back
module segment_intersection_test_unit #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = segit_pkg::FRAC_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   seg_req_if.sink   req_ch,
   seg_rsp_if.source rsp_ch
);
   import segit_pkg::*;

   localparam int D  = COORD_BITS + 1;
   localparam int DW = 2 * COORD_BITS + 2;
   localparam int EW = 3 + 2 * COORD_BITS + 2 * DW + 2 * D;

   logic                         push_valid, push_ready, pop_valid, pop_ready;
   hit_kind_type                 push_kind, pop_kind;
   logic [2:0]                   pop_kind_raw;
   logic signed [COORD_BITS-1:0] push_bx, push_by, pop_bx, pop_by;
   logic [DW-1:0]                push_fa, push_d0, pop_fa, pop_d0;
   logic signed [D-1:0]          push_dx, push_dy, pop_dx, pop_dy;
   logic [EW-1:0]                push_data, pop_data;

   segit_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .push_valid  (push_valid),
      .push_ready  (push_ready),
      .push_kind   (push_kind),
      .push_base_x (push_bx),
      .push_base_y (push_by),
      .push_fa     (push_fa),
      .push_d0     (push_d0),
      .push_dir_x  (push_dx),
      .push_dir_y  (push_dy)
   );

   assign push_data = {push_kind, push_bx, push_by, push_fa, push_d0, push_dx, push_dy};

   segit_queue #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   assign {pop_kind_raw, pop_bx, pop_by, pop_fa, pop_d0, pop_dx, pop_dy} = pop_data;
   assign pop_kind = hit_kind_type'(pop_kind_raw);

   segit_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_kind   (pop_kind),
      .pop_base_x (pop_bx),
      .pop_base_y (pop_by),
      .pop_fa     (pop_fa),
      .pop_d0     (pop_d0),
      .pop_dir_x  (pop_dx),
      .pop_dir_y  (pop_dy),
      .rsp_ch     (rsp_ch)
   );

endmodule

// ===== rtl/segit_front.sv =====
// front end: takes segment pairs, forms cross/dot products, classifies the hit
// depends on segit_pkg and seg_req_if
module segit_front #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   seg_req_if.sink                       req_ch,
   output logic                          push_valid,
   input  logic                          push_ready,
   output segit_pkg::hit_kind_type       push_kind,
   output logic signed [COORD_BITS-1:0]  push_base_x,
   output logic signed [COORD_BITS-1:0]  push_base_y,
   output logic [2*COORD_BITS+1:0]       push_fa,
   output logic [2*COORD_BITS+1:0]       push_d0,
   output logic signed [COORD_BITS:0]    push_dir_x,
   output logic signed [COORD_BITS:0]    push_dir_y
);
   import segit_pkg::*;

   localparam int D  = COORD_BITS + 1;
   localparam int DW = 2 * COORD_BITS + 2;

   function automatic logic signed [D-1:0] dif(logic signed [COORD_BITS-1:0] a,
                                               logic signed [COORD_BITS-1:0] b);
      return D'(a) - D'(b);
   endfunction

   logic s1_en, s2_en;

   // endpoints in test order: b start, b end, a start, a end
   logic signed [COORD_BITS-1:0] ep_x_in [4];
   logic signed [COORD_BITS-1:0] ep_y_in [4];
   logic signed [D-1:0] v1x_in [4];
   logic signed [D-1:0] v1y_in [4];
   logic signed [D-1:0] v2x_in [4];
   logic signed [D-1:0] v2y_in [4];
   logic signed [D-1:0] vwx_in, vwy_in, dx_in, dy_in, wx_in, wy_in;

   logic                         s1_v_ff;
   logic signed [COORD_BITS-1:0] ep1_x_ff [4];
   logic signed [COORD_BITS-1:0] ep1_y_ff [4];
   logic signed [D-1:0] v1x_ff [4];
   logic signed [D-1:0] v1y_ff [4];
   logic signed [D-1:0] v2x_ff [4];
   logic signed [D-1:0] v2y_ff [4];
   logic signed [D-1:0] vwx_ff, vwy_ff, dx_ff, dy_ff, wx_ff, wy_ff;

   logic signed [DW-1:0] cr_in [4];
   logic signed [DW-1:0] dt_in [4];
   logic signed [DW-1:0] d0_in, fa_in, fb_in;

   logic                         s2_v_ff;
   logic signed [COORD_BITS-1:0] ep2_x_ff [4];
   logic signed [COORD_BITS-1:0] ep2_y_ff [4];
   logic signed [DW-1:0] cr_ff [4];
   logic signed [DW-1:0] dt_ff [4];
   logic signed [DW-1:0] d0_ff, fa_ff, fb_ff;
   logic signed [D-1:0]  dx2_ff, dy2_ff;

   logic signed [DW-1:0] d0n, fan, fbn;
   logic [3:0]           on_seg;
   logic                 cross_hit;

   assign s2_en        = !s2_v_ff || push_ready;
   assign s1_en        = !s1_v_ff || s2_en;
   assign req_ch.ready = s1_en;
   assign push_valid   = s2_v_ff;

   always_comb begin
      ep_x_in[0] = req_ch.b_start_x;  ep_y_in[0] = req_ch.b_start_y;
      ep_x_in[1] = req_ch.b_end_x;    ep_y_in[1] = req_ch.b_end_y;
      ep_x_in[2] = req_ch.a_start_x;  ep_y_in[2] = req_ch.a_start_y;
      ep_x_in[3] = req_ch.a_end_x;    ep_y_in[3] = req_ch.a_end_y;
      for (int i = 0; i < 4; i++) begin
         // b endpoints are tested against a, a endpoints against b
         if (i < 2) begin
            v1x_in[i] = dif(req_ch.a_start_x, ep_x_in[i]);
            v1y_in[i] = dif(req_ch.a_start_y, ep_y_in[i]);
            v2x_in[i] = dif(ep_x_in[i], req_ch.a_end_x);
            v2y_in[i] = dif(ep_y_in[i], req_ch.a_end_y);
         end else begin
            v1x_in[i] = dif(req_ch.b_start_x, ep_x_in[i]);
            v1y_in[i] = dif(req_ch.b_start_y, ep_y_in[i]);
            v2x_in[i] = dif(ep_x_in[i], req_ch.b_end_x);
            v2y_in[i] = dif(ep_y_in[i], req_ch.b_end_y);
         end
      end
      vwx_in = dif(req_ch.b_start_x, req_ch.a_start_x);
      vwy_in = dif(req_ch.b_start_y, req_ch.a_start_y);
      dx_in  = dif(req_ch.a_end_x, req_ch.a_start_x);
      dy_in  = dif(req_ch.a_end_y, req_ch.a_start_y);
      wx_in  = dif(req_ch.b_start_x, req_ch.b_end_x);
      wy_in  = dif(req_ch.b_start_y, req_ch.b_end_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (s1_en) begin
         s1_v_ff <= req_ch.valid;
      end
      if (s1_en) begin
         for (int i = 0; i < 4; i++) begin
            ep1_x_ff[i] <= ep_x_in[i];
            ep1_y_ff[i] <= ep_y_in[i];
            v1x_ff[i]   <= v1x_in[i];
            v1y_ff[i]   <= v1y_in[i];
            v2x_ff[i]   <= v2x_in[i];
            v2y_ff[i]   <= v2y_in[i];
         end
         vwx_ff <= vwx_in;
         vwy_ff <= vwy_in;
         dx_ff  <= dx_in;
         dy_ff  <= dy_in;
         wx_ff  <= wx_in;
         wy_ff  <= wy_in;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         cr_in[i] = DW'(v1x_ff[i]) * DW'(v2y_ff[i]) - DW'(v1y_ff[i]) * DW'(v2x_ff[i]);
         dt_in[i] = DW'(v1x_ff[i]) * DW'(v2x_ff[i]) + DW'(v1y_ff[i]) * DW'(v2y_ff[i]);
      end
      d0_in = DW'(dx_ff) * DW'(wy_ff) - DW'(dy_ff) * DW'(wx_ff);
      fa_in = DW'(vwx_ff) * DW'(wy_ff) - DW'(vwy_ff) * DW'(wx_ff);
      fb_in = DW'(dx_ff) * DW'(vwy_ff) - DW'(dy_ff) * DW'(vwx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else if (s2_en) begin
         s2_v_ff <= s1_v_ff;
      end
      if (s2_en) begin
         for (int i = 0; i < 4; i++) begin
            ep2_x_ff[i] <= ep1_x_ff[i];
            ep2_y_ff[i] <= ep1_y_ff[i];
            cr_ff[i]    <= cr_in[i];
            dt_ff[i]    <= dt_in[i];
         end
         d0_ff  <= d0_in;
         fa_ff  <= fa_in;
         fb_ff  <= fb_in;
         dx2_ff <= dx_ff;
         dy2_ff <= dy_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         on_seg[i] = (cr_ff[i] == '0) && !dt_ff[i][DW-1];
      end
      // normalize so that d0 is non-negative
      d0n = d0_ff;
      fan = fa_ff;
      fbn = fb_ff;
      if (d0_ff[DW-1]) begin
         d0n = -d0_ff;
         fan = -fa_ff;
         fbn = -fb_ff;
      end
      cross_hit = (d0_ff != '0) && (fan > 0) && (fan < d0n) && (fbn > 0) && (fbn < d0n);

      push_kind   = HIT_NONE;
      push_base_x = ep2_x_ff[2];
      push_base_y = ep2_y_ff[2];
      if (on_seg[0]) begin
         push_kind   = HIT_B_START;
         push_base_x = ep2_x_ff[0];
         push_base_y = ep2_y_ff[0];
      end else if (on_seg[1]) begin
         push_kind   = HIT_B_END;
         push_base_x = ep2_x_ff[1];
         push_base_y = ep2_y_ff[1];
      end else if (on_seg[2]) begin
         push_kind   = HIT_A_START;
      end else if (on_seg[3]) begin
         push_kind   = HIT_A_END;
         push_base_x = ep2_x_ff[3];
         push_base_y = ep2_y_ff[3];
      end else if (cross_hit) begin
         push_kind   = HIT_CROSS;
      end
      push_fa    = fan;
      push_d0    = d0n;
      push_dir_x = dx2_ff;
      push_dir_y = dy2_ff;
   end

endmodule

// ===== rtl/segit_queue.sv =====
// small register fifo between the classifier and the divider pipeline
// depends on segment_intersection_test_unit_defines.svh
`include "segment_intersection_test_unit_defines.svh"

module segit_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff;
   logic             push, pop;

   assign push_ready = (count_ff != CW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + AW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + AW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SEGIT_ASSERT_NEVER(a_count_range, count_ff > CW'(DEPTH), "queue count beyond depth")
   `SEGIT_ASSERT_NEXT(a_push_grows, push && !pop, count_ff == $past(count_ff) + CW'(1), "push lost")
   `SEGIT_ASSERT_NEXT(a_pop_shrinks, pop && !push, count_ff == $past(count_ff) - CW'(1), "pop lost")

endmodule

// ===== rtl/segit_back.sv =====
// back end: pipelined multiply-divide for the crossing point and the output register
// depends on segit_pkg and seg_rsp_if
module segit_back #(
   parameter int COORD_BITS = segit_pkg::COORD_BITS_DEF,
   parameter int FRAC_BITS  = segit_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  segit_pkg::hit_kind_type       pop_kind,
   input  logic signed [COORD_BITS-1:0]  pop_base_x,
   input  logic signed [COORD_BITS-1:0]  pop_base_y,
   input  logic [2*COORD_BITS+1:0]       pop_fa,
   input  logic [2*COORD_BITS+1:0]       pop_d0,
   input  logic signed [COORD_BITS:0]    pop_dir_x,
   input  logic signed [COORD_BITS:0]    pop_dir_y,
   seg_rsp_if.source                     rsp_ch
);
   import segit_pkg::*;

   localparam int D  = COORD_BITS + 1;
   localparam int DW = 2 * COORD_BITS + 2;
   localparam int RW = DW + 1;
   localparam int N  = D + FRAC_BITS;
   localparam int XW = (COORD_BITS + FRAC_BITS + 3 > 33) ? COORD_BITS + FRAC_BITS + 3 : 33;
   localparam logic signed [XW-1:0] PMAX = XW'(32'sh7FFF_FFFF);
   localparam logic signed [XW-1:0] PMIN = XW'(32'sh8000_0000);

   // one radix-2 step of (fa * m) / d0: shift in a multiplier bit, take a digit 0..2
   function automatic logic [N+DW-1:0] div_step(logic [DW-1:0] rem, logic [N-1:0] q,
                                                logic bit_in, logic [DW-1:0] fa,
                                                logic [DW-1:0] d0);
      logic [RW-1:0] r2, d1, d2;
      logic [N-1:0]  qs;
      r2 = {rem, 1'b0} + (bit_in ? RW'(fa) : RW'(0));
      d1 = RW'(d0);
      d2 = {d0, 1'b0};
      qs = {q[N-2:0], 1'b0};
      if (r2 >= d2) begin
         return {qs + N'(2), DW'(r2 - d2)};
      end else if (r2 >= d1) begin
         return {qs + N'(1), DW'(r2 - d1)};
      end
      return {qs, DW'(r2)};
   endfunction

   function automatic logic signed [31:0] sat(logic signed [XW-1:0] v);
      if (v > PMAX) begin
         return 32'sh7FFF_FFFF;
      end else if (v < PMIN) begin
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   logic adv;
   logic [D-1:0] mag_x, mag_y;

   logic                         st_v_ff    [N];
   hit_kind_type                 st_kind_ff [N];
   logic signed [COORD_BITS-1:0] st_bx_ff   [N];
   logic signed [COORD_BITS-1:0] st_by_ff   [N];
   logic [DW-1:0]                st_fa_ff   [N];
   logic [DW-1:0]                st_d0_ff   [N];
   logic                         st_nx_ff   [N];
   logic                         st_ny_ff   [N];
   logic [DW-1:0]                st_rx_ff   [N];
   logic [DW-1:0]                st_ry_ff   [N];
   logic [N-1:0]                 st_qx_ff   [N];
   logic [N-1:0]                 st_qy_ff   [N];
   logic [N-1:0]                 st_mx_ff   [N];
   logic [N-1:0]                 st_my_ff   [N];

   logic                     rsp_v_ff;
   hit_kind_type             rsp_kind_ff;
   logic signed [31:0]       rsp_x_ff, rsp_y_ff;
   logic signed [XW-1:0]     fix_x, fix_y, val_x, val_y;
   logic signed [31:0]       pt_x_in, pt_y_in;

   assign adv       = !rsp_v_ff || rsp_ch.ready;
   assign pop_ready = adv;
   assign mag_x     = pop_dir_x[D-1] ? D'(-pop_dir_x) : D'(pop_dir_x);
   assign mag_y     = pop_dir_y[D-1] ? D'(-pop_dir_y) : D'(pop_dir_y);

   for (genvar s = 0; s < N; s++) begin : g_stage
      logic                         v_i, nx_i, ny_i;
      hit_kind_type                 kind_i;
      logic signed [COORD_BITS-1:0] bx_i, by_i;
      logic [DW-1:0]                fa_i, d0_i, rx_i, ry_i;
      logic [N-1:0]                 qx_i, qy_i, mx_i, my_i;
      logic [N+DW-1:0]              sx_in, sy_in;

      if (s == 0) begin : g_head
         always_comb begin
            v_i = pop_valid;      kind_i = pop_kind;
            bx_i = pop_base_x;    by_i = pop_base_y;
            fa_i = pop_fa;        d0_i = pop_d0;
            nx_i = pop_dir_x[D-1];
            ny_i = pop_dir_y[D-1];
            rx_i = '0;            ry_i = '0;
            qx_i = '0;            qy_i = '0;
            mx_i = N'(mag_x) << FRAC_BITS;
            my_i = N'(mag_y) << FRAC_BITS;
         end
      end else begin : g_body
         always_comb begin
            v_i = st_v_ff[s-1];   kind_i = st_kind_ff[s-1];
            bx_i = st_bx_ff[s-1]; by_i = st_by_ff[s-1];
            fa_i = st_fa_ff[s-1]; d0_i = st_d0_ff[s-1];
            nx_i = st_nx_ff[s-1]; ny_i = st_ny_ff[s-1];
            rx_i = st_rx_ff[s-1]; ry_i = st_ry_ff[s-1];
            qx_i = st_qx_ff[s-1]; qy_i = st_qy_ff[s-1];
            mx_i = st_mx_ff[s-1]; my_i = st_my_ff[s-1];
         end
      end

      assign sx_in = div_step(rx_i, qx_i, mx_i[N-1], fa_i, d0_i);
      assign sy_in = div_step(ry_i, qy_i, my_i[N-1], fa_i, d0_i);

      always_ff @(posedge clock) begin
         if (reset) begin
            st_v_ff[s] <= 1'b0;
         end else if (adv) begin
            st_v_ff[s] <= v_i;
         end
         if (adv) begin
            st_kind_ff[s] <= kind_i;
            st_bx_ff[s]   <= bx_i;
            st_by_ff[s]   <= by_i;
            st_fa_ff[s]   <= fa_i;
            st_d0_ff[s]   <= d0_i;
            st_nx_ff[s]   <= nx_i;
            st_ny_ff[s]   <= ny_i;
            st_qx_ff[s]   <= sx_in[N+DW-1:DW];
            st_rx_ff[s]   <= sx_in[DW-1:0];
            st_qy_ff[s]   <= sy_in[N+DW-1:DW];
            st_ry_ff[s]   <= sy_in[DW-1:0];
            st_mx_ff[s]   <= {mx_i[N-2:0], 1'b0};
            st_my_ff[s]   <= {my_i[N-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      fix_x = XW'(st_bx_ff[N-1]) <<< FRAC_BITS;
      fix_y = XW'(st_by_ff[N-1]) <<< FRAC_BITS;
      // negative direction floors: subtract one more on a nonzero remainder
      if (st_nx_ff[N-1]) begin
         val_x = fix_x - $signed(XW'(st_qx_ff[N-1])) - $signed(XW'(st_rx_ff[N-1] != '0));
      end else begin
         val_x = fix_x + $signed(XW'(st_qx_ff[N-1]));
      end
      if (st_ny_ff[N-1]) begin
         val_y = fix_y - $signed(XW'(st_qy_ff[N-1])) - $signed(XW'(st_ry_ff[N-1] != '0));
      end else begin
         val_y = fix_y + $signed(XW'(st_qy_ff[N-1]));
      end
      case (st_kind_ff[N-1])
         HIT_CROSS: begin
            pt_x_in = sat(val_x);
            pt_y_in = sat(val_y);
         end
         HIT_B_START, HIT_B_END, HIT_A_START, HIT_A_END: begin
            pt_x_in = sat(fix_x);
            pt_y_in = sat(fix_y);
         end
         default: begin
            pt_x_in = '0;
            pt_y_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= st_v_ff[N-1];
      end
      if (adv) begin
         rsp_kind_ff <= st_kind_ff[N-1];
         rsp_x_ff    <= pt_x_in;
         rsp_y_ff    <= pt_y_in;
      end
   end

   assign rsp_ch.valid    = rsp_v_ff;
   assign rsp_ch.hit_kind = rsp_kind_ff;
   assign rsp_ch.point_x  = rsp_x_ff;
   assign rsp_ch.point_y  = rsp_y_ff;

endmodule
